// ----- hw/rtl/vwr_pkg.sv -----
// Shared types and constants for the vertex weld and remap block.
// No dependencies; imported by every module of the block.
package vwr_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int COORD_W      = 24;
	localparam int TOL_W        = 24;
	localparam int TOLSQ_W      = 2 * TOL_W;
	localparam int NEW_IDX_W    = 6;
	localparam int UCOUNT_W     = 7;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_coord;
		logic signed [COORD_W-1:0] y_coord;
		logic signed [COORD_W-1:0] z_coord;
	} vwr_pos_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_coord;
		logic signed [COORD_W-1:0] y_coord;
		logic signed [COORD_W-1:0] z_coord;
		logic                      last_vertex;
	} vwr_in_t;

	typedef struct packed {
		logic [NEW_IDX_W-1:0] new_index;
		logic [UCOUNT_W-1:0]  unique_count;
		logic                 overflow;
		logic                 last_result;
	} vwr_out_t;

endpackage

// ----- hw/rtl/vwr_dist_pipe.sv -----
// Three-stage squared-distance pipeline with tolerance compare and tag pass-through.
// Depends on vwr_pkg.
module vwr_dist_pipe import vwr_pkg::*; #(
	parameter int TAG_W = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_v,
	input  vwr_pos_t            pa,
	input  vwr_pos_t            pb,
	input  logic [TAG_W-1:0]    in_tag,
	input  logic [TOLSQ_W-1:0]  tol_sq,
	output logic                out_v,
	output logic                out_close,
	output logic [TAG_W-1:0]    out_tag,
	output logic                busy
);

	localparam int D_W  = COORD_W + 1;
	localparam int SQ_W = 2 * D_W;
	localparam int SUM_W = SQ_W + 2;

	logic signed [D_W-1:0] dx, dy, dz;
	logic [D_W-1:0]        ax_s1, ay_s1, az_s1;
	logic [SQ_W-1:0]       sx_s2, sy_s2, sz_s2;
	logic [SUM_W-1:0]      sum;
	logic                  v_s1, v_s2;
	logic [TAG_W-1:0]      tag_s1, tag_s2;

	assign dx = D_W'(pa.x_coord) - D_W'(pb.x_coord);
	assign dy = D_W'(pa.y_coord) - D_W'(pb.y_coord);
	assign dz = D_W'(pa.z_coord) - D_W'(pb.z_coord);
	assign sum = SUM_W'(sx_s2) + SUM_W'(sy_s2) + SUM_W'(sz_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			out_v <= 1'b0;
		end else begin
			v_s1  <= in_v;
			v_s2  <= v_s1;
			out_v <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1     <= dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
		ay_s1     <= dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
		az_s1     <= dz[D_W-1] ? D_W'(-dz) : D_W'(dz);
		tag_s1    <= in_tag;
		sx_s2     <= SQ_W'(ax_s1) * SQ_W'(ax_s1);
		sy_s2     <= SQ_W'(ay_s1) * SQ_W'(ay_s1);
		sz_s2     <= SQ_W'(az_s1) * SQ_W'(az_s1);
		tag_s2    <= tag_s1;
		out_close <= sum < SUM_W'(tol_sq);
		out_tag   <= tag_s2;
	end

	assign busy = v_s1 | v_s2 | out_v;

endmodule

// ----- hw/rtl/vertex_weld_remap.sv -----
// Vertex weld and remap: top level with the position, link and label memories.
// Depends on vwr_pkg and vwr_dist_pipe.
//
// Vertices load one per cycle into a position memory; the request flagged last starts
// the weld. For n stored vertices, vertex i is compared against vertices 0..i-1 through
// a pipelined distance unit fed by the single read port of the position memory, then a
// sweep rewrites the group links of every merged group to its lowest member. A labelling
// pass and the result pass follow, one result per vertex in load order. Vertices beyond
// capacity are dropped and flagged on every result of the set. No request is taken while
// a weld runs.
module vertex_weld_remap import vwr_pkg::*; #(
	parameter int MAX_VERTS = MAX_VERTICES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vtx_valid,
	output logic             vtx_ready,
	input  vwr_in_t          vtx,
	output logic             res_valid,
	input  logic             res_ready,
	output vwr_out_t         res,
	input  logic             cfg_we,
	input  logic [TOL_W-1:0] cfg_wdata
);

	localparam int IDX_W = $clog2(MAX_VERTS);
	localparam int CNT_W = $clog2(MAX_VERTS + 1);

	typedef enum logic [3:0] {
		ST_LOAD, ST_CUR_RD, ST_CUR_CAP, ST_SCAN, ST_SWEEP,
		ST_LABEL, ST_OUT_REP, ST_OUT_LAB, ST_OUT_CAP
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q, n_q, i_q, j_q, g_q;
	logic                 ovf_q;
	logic [TOL_W-1:0]     tol_q;
	logic [TOLSQ_W-1:0]   tol_sq_q;
	vwr_pos_t             cur_q;
	logic [MAX_VERTS-1:0] mask_q;
	logic [IDX_W-1:0]     m_q;
	logic                 rd_v_s1, sw_v_s1, lbl_v_s1;
	logic [IDX_W-1:0]     sw_idx_s1, lbl_idx_s1;
	vwr_out_t             res_q;
	logic                 res_valid_q;

	vwr_pos_t             pos_mem [MAX_VERTS];
	logic [IDX_W-1:0]     rep_mem [MAX_VERTS];
	logic [UCOUNT_W-1:0]  lbl_mem [MAX_VERTS];
	vwr_pos_t             pos_rdata;
	logic [IDX_W-1:0]     rep_rdata;
	logic [UCOUNT_W-1:0]  lbl_rdata;

	logic                 accept, store, issue_scan, issue_sweep, issue_lbl;
	logic [IDX_W-1:0]     pos_raddr, rep_raddr;
	logic                 rep_we, lbl_we;
	logic [IDX_W-1:0]     rep_waddr;
	logic                 d_v, d_close, d_busy;
	logic [IDX_W-1:0]     d_tag;
	logic                 res_free, is_last;

	assign vtx_ready   = state_q == ST_LOAD;
	assign accept      = vtx_valid && vtx_ready;
	assign store       = accept && (cnt_q < CNT_W'(MAX_VERTS));
	assign issue_scan  = (state_q == ST_SCAN) && (j_q < i_q);
	assign issue_sweep = (state_q == ST_SWEEP) && (j_q <= i_q);
	assign issue_lbl   = (state_q == ST_LABEL) && (j_q < n_q);
	assign pos_raddr   = (state_q == ST_CUR_RD) ? i_q[IDX_W-1:0] : j_q[IDX_W-1:0];
	assign rep_raddr   = (state_q inside {ST_OUT_REP, ST_OUT_LAB, ST_OUT_CAP}) ?
		i_q[IDX_W-1:0] : j_q[IDX_W-1:0];
	assign rep_we      = sw_v_s1 && ((sw_idx_s1 == i_q[IDX_W-1:0]) || mask_q[rep_rdata]);
	assign rep_waddr   = sw_idx_s1;
	assign lbl_we      = lbl_v_s1 && (rep_rdata == lbl_idx_s1);
	assign res_free    = !res_valid_q || res_ready;
	assign is_last     = CNT_W'(i_q + 1'b1) == n_q;
	assign res_valid   = res_valid_q;
	assign res         = res_q;

	always_ff @(posedge clk) begin
		if (store) begin
			pos_mem[cnt_q[IDX_W-1:0]] <= '{vtx.x_coord, vtx.y_coord, vtx.z_coord};
		end
		pos_rdata <= pos_mem[pos_raddr];
	end

	always_ff @(posedge clk) begin
		if (rep_we) begin
			rep_mem[rep_waddr] <= m_q;
		end
		rep_rdata <= rep_mem[rep_raddr];
	end

	always_ff @(posedge clk) begin
		if (lbl_we) begin
			lbl_mem[lbl_idx_s1] <= g_q[UCOUNT_W-1:0];
		end
		lbl_rdata <= lbl_mem[rep_rdata];
	end

	vwr_dist_pipe #(.TAG_W(IDX_W)) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_v      (rd_v_s1),
		.pa        (cur_q),
		.pb        (pos_rdata),
		.in_tag    (rep_rdata),
		.tol_sq    (tol_sq_q),
		.out_v     (d_v),
		.out_close (d_close),
		.out_tag   (d_tag),
		.busy      (d_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		cur_q      <= (state_q == ST_CUR_CAP) ? pos_rdata : cur_q;
		sw_idx_s1  <= j_q[IDX_W-1:0];
		lbl_idx_s1 <= j_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			g_q         <= '0;
			ovf_q       <= 1'b0;
			tol_sq_q    <= '0;
			mask_q      <= '0;
			m_q         <= '0;
			rd_v_s1     <= 1'b0;
			sw_v_s1     <= 1'b0;
			lbl_v_s1    <= 1'b0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			rd_v_s1  <= issue_scan;
			sw_v_s1  <= issue_sweep;
			lbl_v_s1 <= issue_lbl;
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (d_v && d_close) begin
				mask_q[d_tag] <= 1'b1;
				if (d_tag < m_q) begin
					m_q <= d_tag;
				end
			end
			if (lbl_we) begin
				g_q <= CNT_W'(g_q + 1'b1);
			end
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (store) begin
							cnt_q <= CNT_W'(cnt_q + 1'b1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (vtx.last_vertex) begin
							n_q      <= store ? CNT_W'(cnt_q + 1'b1) : cnt_q;
							tol_sq_q <= TOLSQ_W'(tol_q) * TOLSQ_W'(tol_q);
							i_q      <= '0;
							state_q  <= ST_CUR_RD;
						end
					end
				end
				ST_CUR_RD: begin
					state_q <= ST_CUR_CAP;
				end
				ST_CUR_CAP: begin
					j_q     <= '0;
					mask_q  <= '0;
					m_q     <= i_q[IDX_W-1:0];
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (issue_scan) begin
						j_q <= CNT_W'(j_q + 1'b1);
					end else if (!rd_v_s1 && !d_busy) begin
						j_q     <= '0;
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (issue_sweep) begin
						j_q <= CNT_W'(j_q + 1'b1);
					end else if (!sw_v_s1) begin
						i_q <= CNT_W'(i_q + 1'b1);
						j_q <= '0;
						g_q <= '0;
						state_q <= is_last ? ST_LABEL : ST_CUR_RD;
					end
				end
				ST_LABEL: begin
					if (issue_lbl) begin
						j_q <= CNT_W'(j_q + 1'b1);
					end else if (!lbl_v_s1) begin
						i_q     <= '0;
						state_q <= ST_OUT_REP;
					end
				end
				ST_OUT_REP: begin
					state_q <= ST_OUT_LAB;
				end
				ST_OUT_LAB: begin
					state_q <= ST_OUT_CAP;
				end
				ST_OUT_CAP: begin
					if (res_free) begin
						res_valid_q        <= 1'b1;
						res_q.new_index    <= NEW_IDX_W'(lbl_rdata);
						res_q.unique_count <= UCOUNT_W'(g_q);
						res_q.overflow     <= ovf_q;
						res_q.last_result  <= is_last;
						if (is_last) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							i_q     <= CNT_W'(i_q + 1'b1);
							state_q <= ST_OUT_REP;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/vwr_checker.sv -----
// Port-level checks for the vertex weld and remap block, bound to the top level.
// Depends on vwr_pkg and vertex_weld_remap.
module vwr_checker import vwr_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             vtx_valid,
	input logic             vtx_ready,
	input vwr_in_t          vtx,
	input logic             res_valid,
	input logic             res_ready,
	input vwr_out_t         res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_vtx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && !vtx_ready |=> vtx_valid && $stable(vtx))
		else $error("request changed while stalled");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> UCOUNT_W'(res.new_index) < res.unique_count)
		else $error("new index not below unique count");

	a_count_nz: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.unique_count != '0)
		else $error("zero unique count on a result");

	a_load_last: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_ready && res_valid |-> res.last_result)
		else $error("loading while a set is still being emitted");

endmodule

bind vertex_weld_remap vwr_checker u_vwr_checker (.*);
